// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next cycle");
`define ASSERT_ALWAYS(lbl, clk, rst_n, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (c)) \
        else $error("assertion failed: invariant");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`define ASSERT_ALWAYS(lbl, clk, rst_n, c)
`endif
`endif

// File: hdl/c8_pkg.sv
// ---------------------------------------------------------------------------
// c8_pkg
// Types, constants and decode helpers for the CHIP-8 instruction core.
// ---------------------------------------------------------------------------
package c8_pkg;

    localparam int MEM_BYTES      = 4096;
    localparam int MEM_AW         = 12;
    localparam int DISP_BYTES     = 256;
    localparam int DISP_AW        = 8;
    localparam int STACK_DEPTH_DEF = 16;
    localparam logic [11:0] START_RESET = 12'h200;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // instruction classes, pick the sequence after execute
    localparam logic [2:0] CLS_SIMPLE = 3'd0;
    localparam logic [2:0] CLS_FLAG   = 3'd1;
    localparam logic [2:0] CLS_DRAW   = 3'd2;
    localparam logic [2:0] CLS_BCD    = 3'd3;
    localparam logic [2:0] CLS_STORE  = 3'd4;
    localparam logic [2:0] CLS_LOAD   = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] address;
        logic [7:0]  data;
        logic [15:0] keys;
        logic [7:0]  random_byte;
    } req_t;

    typedef struct packed {
        logic [11:0] pc;
        logic [15:0] opcode;
        logic [7:0]  display_byte;
        logic        draw_flag;
        logic        beep;
        logic        waiting_for_key;
        logic        unknown_opcode;
    } rsp_t;

    typedef struct packed {
        logic clr;
        logic take;
        logic cap_hi;
        logic cap_lo;
        logic rd_regs;
        logic exec;
        logic vf_wr;
        logic dm_rd;
        logic dm_row;
        logic da;
        logic db;
        logic bcd;
        logic st_rd;
        logic st_wr;
        logic ld_rd;
        logic ld_wr;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic       clr_last;
        logic [2:0] cls;
        logic       n_zero;
        logic       cnt_last;
        logic       out_busy;
    } stat_t;

    typedef struct packed {
        logic [2:0] cls;
        logic       unk;
    } dec_t;

    function automatic dec_t decode(input logic [15:0] op);
        dec_t d;
        d.cls = CLS_SIMPLE;
        d.unk = 1'b0;
        case (op[15:12])
            4'h0: d.unk = !(op == 16'h00E0 || op == 16'h00EE);
            4'h5, 4'h9: d.unk = (op[3:0] != 4'h0);
            4'h8:
            begin
                case (op[3:0])
                    4'h0, 4'h1, 4'h2, 4'h3: d.cls = CLS_SIMPLE;
                    4'h4, 4'h5, 4'h6, 4'h7, 4'hE: d.cls = CLS_FLAG;
                    default: d.unk = 1'b1;
                endcase
            end
            4'hD: d.cls = CLS_DRAW;
            4'hE: d.unk = !(op[7:0] == 8'h9E || op[7:0] == 8'hA1);
            4'hF:
            begin
                case (op[7:0])
                    8'h07, 8'h0A, 8'h15, 8'h18, 8'h29: d.cls = CLS_SIMPLE;
                    8'h1E: d.cls = CLS_FLAG;
                    8'h33: d.cls = CLS_BCD;
                    8'h55: d.cls = CLS_STORE;
                    8'h65: d.cls = CLS_LOAD;
                    default: d.unk = 1'b1;
                endcase
            end
            default: d.unk = 1'b0;
        endcase
        return d;
    endfunction

    // decimal digit k of v: 0 hundreds, 1 tens, 2 ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] k);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [17:0] m;
        logic [3:0]  t;
        logic [7:0]  o;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = v - 8'(h * 7'd100);
        m = 18'(r) * 18'd205;   // r / 10 for r < 100
        t = m[14:11];
        o = r - 8'(t * 4'd10);
        case (k)
            2'd0: bcd_digit = {6'd0, h};
            2'd1: bcd_digit = {4'd0, t};
            default: bcd_digit = o;
        endcase
    endfunction

endpackage

// File: hdl/c8_chan_if.sv
// ---------------------------------------------------------------------------
// c8_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ---------------------------------------------------------------------------
interface c8_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/chip8_instruction_core.sv
// ---------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 interpreter core: memory load, single-instruction execute, display read.
// ---------------------------------------------------------------------------
// req carries one command word (cmd, address, data, keys, random_byte); rsp
// returns one word per command with pc, opcode, display_byte and status bits.
// cfg_we/cfg_wdata set the start address and reload the program counter.
// After reset the main memory is cleared, one byte per cycle: req.ready stays
// low until all 4096 bytes are cleared. Registers, stack, timers and display
// start at zero. One command is in work at a time. Execute goes through fetch,
// register read and execute, plus a VF write for flag instructions, a memory
// read, a display read and two display writes per sprite row (n rows) plus a
// VF write for sprite draw, three digit writes for Fx33 and a read and a write
// per register for Fx55/Fx65, set by the single memory port and register file
// read port. The result sits in an output register; a new command is accepted
// while it waits, but the next result holds until rsp is drained.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chip8_instruction_core #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    c8_chan_if.sink     req,
    c8_chan_if.source   rsp,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata
);

    c8_pkg::ctl_t  ctl;
    c8_pkg::stat_t st;
    logic          ready;
    c8_pkg::req_t  in_word;
    c8_pkg::rsp_t  out_word;
    logic          out_valid;

    assign in_word     = req.payload;
    assign req.ready   = ready;
    assign rsp.valid   = out_valid;
    assign rsp.payload = out_word;

    c8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (in_word.cmd),
        .st       (st),
        .ready    (ready),
        .ctl      (ctl)
    );

    c8_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .in_word   (in_word),
        .out_ready (rsp.ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .st        (st),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

    `ASSERT_IMPL(a_no_accept_in_clear, clk, rst_n, ctl.clr, !ready)
    `ASSERT_NEXT(a_finish_shows_word, clk, rst_n, ctl.finish, out_valid)
    `ASSERT_ALWAYS(a_one_phase, clk, rst_n, $onehot0({ctl.clr, ctl.take, ctl.exec, ctl.finish}))

endmodule

// File: hdl/c8_ctrl.sv
// ---------------------------------------------------------------------------
// c8_ctrl
// Sequencer: memory clear, fetch, execute and the multi-cycle instruction steps.
// ---------------------------------------------------------------------------
module c8_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     in_cmd,
    input  c8_pkg::stat_t  st,
    output logic           ready,
    output c8_pkg::ctl_t   ctl
);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_F1   = 5'd2;
    localparam logic [4:0] S_F2   = 5'd3;
    localparam logic [4:0] S_RV   = 5'd4;
    localparam logic [4:0] S_EX   = 5'd5;
    localparam logic [4:0] S_VF   = 5'd6;
    localparam logic [4:0] S_DM0  = 5'd7;
    localparam logic [4:0] S_DM1  = 5'd8;
    localparam logic [4:0] S_DA   = 5'd9;
    localparam logic [4:0] S_DB   = 5'd10;
    localparam logic [4:0] S_BCD  = 5'd11;
    localparam logic [4:0] S_ST0  = 5'd12;
    localparam logic [4:0] S_ST1  = 5'd13;
    localparam logic [4:0] S_LD0  = 5'd14;
    localparam logic [4:0] S_LD1  = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_comb
    begin
        ctl        = '0;
        ready      = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                ctl.clr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    ctl.take   = 1'b1;
                    state_next = (in_cmd == c8_pkg::CMD_EXEC) ? S_F1 : S_FIN;
                end
            end
            S_F1:
            begin
                ctl.cap_hi = 1'b1;
                state_next = S_F2;
            end
            S_F2:
            begin
                ctl.cap_lo = 1'b1;
                state_next = S_RV;
            end
            S_RV:
            begin
                ctl.rd_regs = 1'b1;
                state_next  = S_EX;
            end
            S_EX:
            begin
                ctl.exec = 1'b1;
                case (st.cls)
                    c8_pkg::CLS_FLAG:  state_next = S_VF;
                    c8_pkg::CLS_DRAW:  state_next = st.n_zero ? S_VF : S_DM0;
                    c8_pkg::CLS_BCD:   state_next = S_BCD;
                    c8_pkg::CLS_STORE: state_next = S_ST0;
                    c8_pkg::CLS_LOAD:  state_next = S_LD0;
                    default:           state_next = S_FIN;
                endcase
            end
            S_VF:
            begin
                ctl.vf_wr  = 1'b1;
                state_next = S_FIN;
            end
            S_DM0:
            begin
                ctl.dm_rd  = 1'b1;
                state_next = S_DM1;
            end
            S_DM1:
            begin
                ctl.dm_row = 1'b1;
                state_next = S_DA;
            end
            S_DA:
            begin
                ctl.da     = 1'b1;
                state_next = S_DB;
            end
            S_DB:
            begin
                ctl.db     = 1'b1;
                state_next = st.cnt_last ? S_VF : S_DM0;
            end
            S_BCD:
            begin
                ctl.bcd = 1'b1;
                if (st.cnt_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_ST0:
            begin
                ctl.st_rd  = 1'b1;
                state_next = S_ST1;
            end
            S_ST1:
            begin
                ctl.st_wr  = 1'b1;
                state_next = st.cnt_last ? S_FIN : S_ST0;
            end
            S_LD0:
            begin
                ctl.ld_rd  = 1'b1;
                state_next = S_LD1;
            end
            S_LD1:
            begin
                ctl.ld_wr  = 1'b1;
                state_next = st.cnt_last ? S_FIN : S_LD0;
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/c8_datapath.sv
// ---------------------------------------------------------------------------
// c8_datapath
// Memories, registers, timers, stack, display store and the execute logic.
// ---------------------------------------------------------------------------
module c8_datapath #(
    parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  c8_pkg::ctl_t   ctl,
    input  c8_pkg::req_t   in_word,
    input  logic           out_ready,
    input  logic           cfg_we,
    input  logic [11:0]    cfg_wdata,
    output c8_pkg::stat_t  st,
    output logic           out_valid,
    output c8_pkg::rsp_t   out_word
);

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_MAX = SP_W'(STACK_DEPTH - 1);

    logic [7:0]  mem [c8_pkg::MEM_BYTES];
    logic [7:0]  mem_q;
    logic [7:0]  disp [c8_pkg::DISP_BYTES];
    logic [7:0]  disp_q;
    logic        dv_q;
    logic [c8_pkg::DISP_BYTES-1:0] dvalid_reg;
    logic [7:0]  vreg [16];
    logic [15:0] vvalid_reg;
    logic [7:0]  va_q, vb_q;
    logic [11:0] stack_reg [STACK_DEPTH];
    logic [SP_W-1:0] sp_reg;
    logic [15:0] i_reg;
    logic [11:0] pc_reg;
    logic [7:0]  dt_reg, st_reg;
    logic [c8_pkg::MEM_AW-1:0] clr_cnt_reg;
    logic [1:0]  cmd_reg;
    logic [11:0] addr_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [15:0] op_reg;
    logic        draw_reg, wait_reg, unk_reg, flag_reg;
    logic [3:0]  cnt_reg, lim_reg;
    logic [15:0] spr_reg;
    logic        out_valid_reg;
    c8_pkg::rsp_t out_reg;

    c8_pkg::dec_t dec;
    logic [3:0]  x, y, n;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [11:0] i_cnt;
    logic [7:0]  disp_rd;
    logic [4:0]  py;
    logic [2:0]  b0, b1;

    // memory ports
    logic        mem_re, mem_we;
    logic [11:0] mem_ra, mem_wa;
    logic [7:0]  mem_wd;
    logic        disp_re, disp_we;
    logic [7:0]  disp_ra, disp_wa, disp_wd;
    logic        v_we;
    logic [3:0]  v_wa, v_ra, v_rb;
    logic [7:0]  v_wd;

    // execute results
    logic        ex_we;
    logic [7:0]  ex_wd;
    logic [11:0] ex_npc;
    logic        ex_flag, ex_wait, ex_i_we, ex_dt_we, ex_st_we, ex_push, ex_pop, ex_cls;
    logic [15:0] ex_i;
    logic [SP_W-1:0] sp_dec, sp_inc;
    logic [8:0]  add9;
    logic [16:0] add17;
    logic [3:0]  hk;
    logic        key_hit;
    logic        beep;

    assign dec   = c8_pkg::decode(op_reg);
    assign x     = op_reg[11:8];
    assign y     = op_reg[7:4];
    assign n     = op_reg[3:0];
    assign kk    = op_reg[7:0];
    assign nnn   = op_reg[11:0];
    assign i_cnt = i_reg[11:0] + {8'd0, cnt_reg};
    assign disp_rd = dv_q ? disp_q : 8'd0;
    assign py    = vb_q[4:0] + {1'b0, cnt_reg};
    assign b0    = va_q[5:3];
    assign b1    = va_q[5:3] + 3'd1;
    assign sp_dec = (sp_reg == '0) ? SP_MAX : sp_reg - SP_W'(1);
    assign sp_inc = (sp_reg == SP_MAX) ? '0 : sp_reg + SP_W'(1);
    assign beep  = (cmd_reg == c8_pkg::CMD_EXEC) && !wait_reg && (st_reg == 8'd1);

    assign st.clr_last = (clr_cnt_reg == '1);
    assign st.cls      = dec.cls;
    assign st.n_zero   = (n == 4'd0);
    assign st.cnt_last = (cnt_reg == lim_reg);
    assign st.out_busy = out_valid_reg && !out_ready;
    assign out_valid   = out_valid_reg;
    assign out_word    = out_reg;

    // main memory
    always_comb
    begin
        mem_re = ctl.take || ctl.cap_hi || ctl.dm_rd || ctl.ld_rd;
        mem_ra = pc_reg;
        if (ctl.cap_hi)
        begin
            mem_ra = pc_reg + 12'd1;
        end
        else if (ctl.dm_rd || ctl.ld_rd)
        begin
            mem_ra = i_cnt;
        end
        mem_we = 1'b0;
        mem_wa = i_cnt;
        mem_wd = va_q;
        if (ctl.clr)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = 8'd0;
        end
        else if (ctl.take && in_word.cmd == c8_pkg::CMD_WRITE)
        begin
            mem_we = 1'b1;
            mem_wa = in_word.address;
            mem_wd = in_word.data;
        end
        else if (ctl.bcd)
        begin
            mem_we = 1'b1;
            mem_wd = c8_pkg::bcd_digit(va_q, cnt_reg[1:0]);
        end
        else if (ctl.st_wr)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_ra];
        end
    end

    // display store, one byte holds eight pixels, leftmost in bit 7
    always_comb
    begin
        disp_re = (ctl.take && in_word.cmd == c8_pkg::CMD_READ) || ctl.dm_row || ctl.da;
        disp_ra = in_word.address[7:0];
        if (ctl.dm_row)
        begin
            disp_ra = {py, b0};
        end
        else if (ctl.da)
        begin
            disp_ra = {py, b1};
        end
        disp_we = ctl.da || ctl.db;
        disp_wa = ctl.da ? {py, b0} : {py, b1};
        disp_wd = ctl.da ? (disp_rd ^ spr_reg[15:8]) : (disp_rd ^ spr_reg[7:0]);
    end

    always_ff @(posedge clk)
    begin
        if (disp_we)
        begin
            disp[disp_wa] <= disp_wd;
        end
        if (disp_re)
        begin
            disp_q <= disp[disp_ra];
            dv_q   <= dvalid_reg[disp_ra];
        end
    end

    // register file
    always_comb
    begin
        v_ra = ctl.st_rd ? cnt_reg : x;
        v_rb = (op_reg[15:12] == 4'hB) ? 4'd0 : y;
        v_we = 1'b0;
        v_wa = x;
        v_wd = ex_wd;
        if (ctl.exec)
        begin
            v_we = ex_we;
        end
        else if (ctl.vf_wr)
        begin
            v_we = 1'b1;
            v_wa = 4'hF;
            v_wd = {7'd0, flag_reg};
        end
        else if (ctl.ld_wr)
        begin
            v_we = 1'b1;
            v_wa = cnt_reg;
            v_wd = mem_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vreg[v_wa] <= v_wd;
        end
        if (ctl.rd_regs || ctl.st_rd)
        begin
            va_q <= vvalid_reg[v_ra] ? vreg[v_ra] : 8'd0;
        end
        if (ctl.rd_regs)
        begin
            vb_q <= vvalid_reg[v_rb] ? vreg[v_rb] : 8'd0;
        end
    end

    // execute
    always_comb
    begin
        ex_we    = 1'b0;
        ex_wd    = 8'd0;
        ex_npc   = pc_reg + 12'd2;
        ex_flag  = 1'b0;
        ex_wait  = 1'b0;
        ex_i_we  = 1'b0;
        ex_i     = i_reg;
        ex_dt_we = 1'b0;
        ex_st_we = 1'b0;
        ex_push  = 1'b0;
        ex_pop   = 1'b0;
        ex_cls   = 1'b0;
        add9     = {1'b0, va_q} + {1'b0, vb_q};
        add17    = {1'b0, i_reg} + {9'd0, va_q};
        key_hit  = (va_q[7:4] == 4'd0) && keys_reg[va_q[3:0]];
        hk       = 4'd0;
        for (int k = 0; k < 16; k++)
        begin
            if (keys_reg[k])
            begin
                hk = 4'(k);
            end
        end
        case (op_reg[15:12])
            4'h0:
            begin
                if (op_reg == 16'h00E0)
                begin
                    ex_cls = 1'b1;
                end
                else if (op_reg == 16'h00EE)
                begin
                    ex_pop = 1'b1;
                    ex_npc = stack_reg[sp_dec] + 12'd2;
                end
            end
            4'h1: ex_npc = nnn;
            4'h2:
            begin
                ex_push = 1'b1;
                ex_npc  = nnn;
            end
            4'h3: if (va_q == kk) ex_npc = pc_reg + 12'd4;
            4'h4: if (va_q != kk) ex_npc = pc_reg + 12'd4;
            4'h5: if (n == 4'd0 && va_q == vb_q) ex_npc = pc_reg + 12'd4;
            4'h6:
            begin
                ex_we = 1'b1;
                ex_wd = kk;
            end
            4'h7:
            begin
                ex_we = 1'b1;
                ex_wd = va_q + kk;
            end
            4'h8:
            begin
                case (n)
                    4'h0: begin ex_we = 1'b1; ex_wd = vb_q; end
                    4'h1: begin ex_we = 1'b1; ex_wd = va_q | vb_q; end
                    4'h2: begin ex_we = 1'b1; ex_wd = va_q & vb_q; end
                    4'h3: begin ex_we = 1'b1; ex_wd = va_q ^ vb_q; end
                    4'h4: begin ex_we = 1'b1; ex_wd = add9[7:0]; ex_flag = add9[8]; end
                    4'h5: begin ex_we = 1'b1; ex_wd = va_q - vb_q; ex_flag = va_q >= vb_q; end
                    4'h6: begin ex_we = 1'b1; ex_wd = {1'b0, va_q[7:1]}; ex_flag = va_q[0]; end
                    4'h7: begin ex_we = 1'b1; ex_wd = vb_q - va_q; ex_flag = vb_q >= va_q; end
                    4'hE: begin ex_we = 1'b1; ex_wd = {va_q[6:0], 1'b0}; ex_flag = va_q[7]; end
                    default: ex_we = 1'b0;
                endcase
            end
            4'h9: if (n == 4'd0 && va_q != vb_q) ex_npc = pc_reg + 12'd4;
            4'hA:
            begin
                ex_i_we = 1'b1;
                ex_i    = {4'd0, nnn};
            end
            4'hB: ex_npc = {4'd0, vb_q} + nnn;
            4'hC:
            begin
                ex_we = 1'b1;
                ex_wd = rnd_reg & kk;
            end
            4'hE:
            begin
                if (kk == 8'h9E && key_hit)
                begin
                    ex_npc = pc_reg + 12'd4;
                end
                else if (kk == 8'hA1 && !key_hit)
                begin
                    ex_npc = pc_reg + 12'd4;
                end
            end
            4'hF:
            begin
                case (kk)
                    8'h07:
                    begin
                        ex_we = 1'b1;
                        ex_wd = dt_reg;
                    end
                    8'h0A:
                    begin
                        if (keys_reg == 16'd0)
                        begin
                            ex_wait = 1'b1;
                            ex_npc  = pc_reg;
                        end
                        else
                        begin
                            ex_we = 1'b1;
                            ex_wd = {4'd0, hk};
                        end
                    end
                    8'h15: ex_dt_we = 1'b1;
                    8'h18: ex_st_we = 1'b1;
                    8'h1E:
                    begin
                        ex_i_we = 1'b1;
                        ex_i    = add17[15:0];
                        ex_flag = (add17 > 17'h00FFF);
                    end
                    8'h29:
                    begin
                        ex_i_we = 1'b1;
                        ex_i    = ({8'd0, va_q} << 2) + {8'd0, va_q};
                    end
                    default: ex_i_we = 1'b0;
                endcase
            end
            default: ex_we = 1'b0;
        endcase
        if (dec.unk)
        begin
            ex_npc = pc_reg;
        end
    end

    // stack storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                stack_reg[k] <= 12'd0;
            end
        end
        else if (ctl.exec && ex_push)
        begin
            stack_reg[sp_reg] <= pc_reg;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            dvalid_reg    <= '0;
            vvalid_reg    <= '0;
            sp_reg        <= '0;
            i_reg         <= 16'd0;
            pc_reg        <= c8_pkg::START_RESET;
            dt_reg        <= 8'd0;
            st_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                pc_reg <= cfg_wdata;
            end
            if (v_we)
            begin
                vvalid_reg[v_wa] <= 1'b1;
            end
            if (disp_we)
            begin
                dvalid_reg[disp_wa] <= 1'b1;
            end
            if (ctl.exec)
            begin
                pc_reg <= ex_npc;
                if (ex_cls)
                begin
                    dvalid_reg <= '0;
                end
                if (ex_i_we)
                begin
                    i_reg <= ex_i;
                end
                if (ex_dt_we)
                begin
                    dt_reg <= va_q;
                end
                if (ex_st_we)
                begin
                    st_reg <= va_q;
                end
                if (ex_push)
                begin
                    sp_reg <= sp_inc;
                end
                if (ex_pop)
                begin
                    sp_reg <= sp_dec;
                end
            end
            if ((ctl.st_wr || ctl.ld_wr) && st.cnt_last)
            begin
                i_reg <= i_reg + {12'd0, x} + 16'd1;
            end
            if (ctl.finish && cmd_reg == c8_pkg::CMD_EXEC && !wait_reg)
            begin
                if (dt_reg != 8'd0)
                begin
                    dt_reg <= dt_reg - 8'd1;
                end
                if (st_reg != 8'd0)
                begin
                    st_reg <= st_reg - 8'd1;
                end
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-word payload state
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            cmd_reg  <= in_word.cmd;
            addr_reg <= in_word.address;
            keys_reg <= in_word.keys;
            rnd_reg  <= in_word.random_byte;
            op_reg   <= 16'd0;
            draw_reg <= 1'b0;
            wait_reg <= 1'b0;
            unk_reg  <= 1'b0;
        end
        if (ctl.cap_hi)
        begin
            op_reg[15:8] <= mem_q;
        end
        if (ctl.cap_lo)
        begin
            op_reg[7:0] <= mem_q;
        end
        if (ctl.exec)
        begin
            draw_reg <= ex_cls || (op_reg[15:12] == 4'hD);
            wait_reg <= ex_wait;
            unk_reg  <= dec.unk;
            flag_reg <= ex_flag;
            cnt_reg  <= 4'd0;
            case (dec.cls)
                c8_pkg::CLS_DRAW: lim_reg <= n - 4'd1;
                c8_pkg::CLS_BCD:  lim_reg <= 4'd2;
                default:          lim_reg <= x;
            endcase
        end
        if (ctl.dm_row)
        begin
            spr_reg <= {mem_q, 8'd0} >> va_q[2:0];
        end
        if (ctl.da)
        begin
            flag_reg <= flag_reg | (|(disp_rd & spr_reg[15:8]));
        end
        if (ctl.db)
        begin
            flag_reg <= flag_reg | (|(disp_rd & spr_reg[7:0]));
        end
        if (ctl.db || ctl.bcd || ctl.st_wr || ctl.ld_wr)
        begin
            cnt_reg <= cnt_reg + 4'd1;
        end
        if (ctl.finish)
        begin
            out_reg.pc              <= pc_reg;
            out_reg.opcode          <= op_reg;
            out_reg.display_byte    <= (cmd_reg == c8_pkg::CMD_READ && addr_reg[11:8] == 4'd0)
                                       ? disp_rd : 8'd0;
            out_reg.draw_flag       <= draw_reg;
            out_reg.beep            <= beep;
            out_reg.waiting_for_key <= wait_reg;
            out_reg.unknown_opcode  <= unk_reg;
        end
    end

endmodule

// File: test/chip8_instruction_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chip8_instruction_core_test
// Self-checking bench for the CHIP-8 core. A short directed list loads and
// runs a few instructions, then random runs mostly write an instruction at
// the current pc and execute it. Each response word is checked against a fixed
// word or a behavioral model, under changing start addresses and stalls.
// ----------------------------------------------------------------------------
module chip8_instruction_core_test;
    import c8_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 680;

    // instruction groups by top nibble
    typedef enum logic [3:0] {
        GRP_SYS, GRP_JP, GRP_CALL, GRP_SE_IMM, GRP_SNE_IMM, GRP_SE_REG, GRP_LD_IMM,
        GRP_ADD_IMM, GRP_ALU, GRP_SNE_REG, GRP_LD_I, GRP_JP_V0, GRP_RND, GRP_DRW,
        GRP_KEY, GRP_MISC
    } group_e;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;
    localparam logic [7:0] KEY_SKP = 8'h9E, KEY_SKNP = 8'hA1;
    localparam logic [7:0] F_GET_DT = 8'h07, F_WAIT_KEY = 8'h0A, F_SET_DT = 8'h15;
    localparam logic [7:0] F_SET_ST = 8'h18, F_ADD_I = 8'h1E, F_FONT = 8'h29;
    localparam logic [7:0] F_BCD = 8'h33, F_STORE = 8'h55, F_LOAD = 8'h65;

    typedef struct {
        req_t word;
        bit   fixed;
        rsp_t result;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [11:0] cfg_wdata;

    c8_chan_if #(.payload_t(req_t)) req_ch ();
    c8_chan_if #(.payload_t(rsp_t)) rsp_ch ();

    chip8_instruction_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // machine state of the predictor
    logic [7:0]  ram [MEM_BYTES];
    logic        pixels [2048];
    logic [7:0]  vreg [16];
    logic [11:0] ret_stack [16];
    logic [3:0]  sp;
    logic [15:0] ireg;
    logic [11:0] pc_now;
    logic [11:0] start_addr;
    logic [7:0]  delay_t;
    logic [7:0]  sound_t;

    rsp_t expected_rsp [$];
    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    row_t dir_rows [25];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic rsp_t step_machine(input req_t w);
        rsp_t o;
        logic [15:0] op;
        logic [11:0] npc;
        logic [3:0] x, y, n;
        logic [7:0] kk, vx, vy, row;
        logic flag, wait_key;
        int py, p;
        o = '0;
        wait_key = 1'b0;
        if (w.cmd == CMD_WRITE)
            ram[w.address] = w.data;
        else if (w.cmd == CMD_READ)
        begin
            if (w.address < 256)
                for (int b = 0; b < 8; b++)
                    o.display_byte = {o.display_byte[6:0], pixels[w.address * 8 + b]};
        end
        else if (w.cmd == CMD_EXEC)
        begin
            op = {ram[pc_now], ram[12'(pc_now + 1)]};
            o.opcode = op;
            x = op[11:8];
            y = op[7:4];
            n = op[3:0];
            kk = op[7:0];
            vx = vreg[x];
            vy = vreg[y];
            npc = pc_now + 12'd2;
            case (group_e'(op[15:12]))
                GRP_SYS:
                begin
                    if (op == OP_CLS)
                    begin
                        foreach (pixels[i]) pixels[i] = 1'b0;
                        o.draw_flag = 1'b1;
                    end
                    else if (op == OP_RET)
                    begin
                        sp = sp - 4'd1;
                        npc = ret_stack[sp] + 12'd2;
                    end
                    else
                        o.unknown_opcode = 1'b1;
                end
                GRP_JP: npc = op[11:0];
                GRP_CALL:
                begin
                    ret_stack[sp] = pc_now;
                    sp = sp + 4'd1;
                    npc = op[11:0];
                end
                GRP_SE_IMM: if (vx == kk) npc = pc_now + 12'd4;
                GRP_SNE_IMM: if (vx != kk) npc = pc_now + 12'd4;
                GRP_SE_REG:
                    if (n != 0) o.unknown_opcode = 1'b1;
                    else if (vx == vy) npc = pc_now + 12'd4;
                GRP_LD_IMM: vreg[x] = kk;
                GRP_ADD_IMM: vreg[x] = vx + kk;
                GRP_ALU:
                    case (n)
                        ALU_MOV: vreg[x] = vy;
                        ALU_OR: vreg[x] = vx | vy;
                        ALU_AND: vreg[x] = vx & vy;
                        ALU_XOR: vreg[x] = vx ^ vy;
                        ALU_ADD:
                        begin
                            vreg[x] = vx + vy;
                            vreg[15] = (9'(vx) + 9'(vy)) > 9'd255;
                        end
                        ALU_SUB:
                        begin
                            vreg[x] = vx - vy;
                            vreg[15] = vx >= vy;
                        end
                        ALU_SHR:
                        begin
                            vreg[x] = vx >> 1;
                            vreg[15] = vx[0];
                        end
                        ALU_SUBN:
                        begin
                            vreg[x] = vy - vx;
                            vreg[15] = vy >= vx;
                        end
                        ALU_SHL:
                        begin
                            vreg[x] = vx << 1;
                            vreg[15] = vx[7];
                        end
                        default: o.unknown_opcode = 1'b1;
                    endcase
                GRP_SNE_REG:
                    if (n != 0) o.unknown_opcode = 1'b1;
                    else if (vx != vy) npc = pc_now + 12'd4;
                GRP_LD_I: ireg = {4'd0, op[11:0]};
                GRP_JP_V0: npc = 12'(vreg[0]) + op[11:0];
                GRP_RND: vreg[x] = w.random_byte & kk;
                GRP_DRW:
                begin
                    flag = 1'b0;
                    for (int r = 0; r < n; r++)
                    begin
                        row = ram[12'(ireg + 16'(r))];
                        py = (vy + r) % 32;
                        for (int c = 0; c < 8; c++)
                            if (row[7 - c])
                            begin
                                p = py * 64 + (vx + c) % 64;
                                if (pixels[p]) flag = 1'b1;
                                pixels[p] = ~pixels[p];
                            end
                    end
                    vreg[15] = flag;
                    o.draw_flag = 1'b1;
                end
                GRP_KEY:
                    if (kk == KEY_SKP)
                    begin
                        if (vx < 16 && w.keys[vx[3:0]]) npc = pc_now + 12'd4;
                    end
                    else if (kk == KEY_SKNP)
                    begin
                        if (!(vx < 16 && w.keys[vx[3:0]])) npc = pc_now + 12'd4;
                    end
                    else
                        o.unknown_opcode = 1'b1;
                default:
                    case (kk)
                        F_GET_DT: vreg[x] = delay_t;
                        F_WAIT_KEY:
                            if (w.keys == 0)
                            begin
                                wait_key = 1'b1;
                                npc = pc_now;
                            end
                            else
                                for (int k = 0; k < 16; k++)
                                    if (w.keys[k]) vreg[x] = 8'(k);
                        F_SET_DT: delay_t = vx;
                        F_SET_ST: sound_t = vx;
                        F_ADD_I:
                        begin
                            vreg[15] = (17'(ireg) + 17'(vx)) > 17'h0FFF;
                            ireg = ireg + 16'(vx);
                        end
                        F_FONT: ireg = 16'(vx) * 16'd5;
                        F_BCD:
                        begin
                            ram[12'(ireg)] = vx / 100;
                            ram[12'(ireg + 16'd1)] = vx / 10 % 10;
                            ram[12'(ireg + 16'd2)] = vx % 10;
                        end
                        F_STORE:
                        begin
                            for (int i = 0; i <= x; i++) ram[12'(ireg + 16'(i))] = vreg[i];
                            ireg = ireg + 16'(x) + 16'd1;
                        end
                        F_LOAD:
                        begin
                            for (int i = 0; i <= x; i++) vreg[i] = ram[12'(ireg + 16'(i))];
                            ireg = ireg + 16'(x) + 16'd1;
                        end
                        default: o.unknown_opcode = 1'b1;
                    endcase
            endcase
            if (o.unknown_opcode) npc = pc_now;
            pc_now = npc;
            o.waiting_for_key = wait_key;
            if (!wait_key)
            begin
                if (delay_t != 0) delay_t = delay_t - 8'd1;
                if (sound_t != 0)
                begin
                    o.beep = (sound_t == 8'd1);
                    sound_t = sound_t - 8'd1;
                end
            end
        end
        o.pc = pc_now;
        return o;
    endfunction

    task automatic report(input string field, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, want, cycles);
        errors++;
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp.size() == 0)
                report("unexpected word", rsp_ch.payload, 0);
            else
            begin
                rsp_t e;
                rsp_t g;
                e = expected_rsp.pop_front();
                g = rsp_ch.payload;
                if (g.pc !== e.pc) report("pc", g.pc, e.pc);
                if (g.opcode !== e.opcode) report("opcode", g.opcode, e.opcode);
                if (g.display_byte !== e.display_byte)
                    report("display_byte", g.display_byte, e.display_byte);
                if (g.draw_flag !== e.draw_flag) report("draw_flag", g.draw_flag, e.draw_flag);
                if (g.beep !== e.beep) report("beep", g.beep, e.beep);
                if (g.waiting_for_key !== e.waiting_for_key)
                    report("waiting_for_key", g.waiting_for_key, e.waiting_for_key);
                if (g.unknown_opcode !== e.unknown_opcode)
                    report("unknown_opcode", g.unknown_opcode, e.unknown_opcode);
            end
        end
    end

    // response side stalls; a long hold keeps ready low while hold_cycles counts down
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input req_t w, input bit fixed = 0, input rsp_t result = '0);
        rsp_t p;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= w;
        do @(posedge clk); while (!req_ch.ready);
        p = step_machine(w);
        expected_rsp.push_back(fixed ? result : p);
        @(negedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_start(input logic [11:0] a);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= a;
        @(negedge clk);
        cfg_we <= 1'b0;
        start_addr = a;
        pc_now = a;
    endtask

    function automatic logic [15:0] pick_instruction();
        logic [3:0] x, y, n;
        logic [7:0] kk;
        group_e g;
        logic [3:0] alu_ops [9];
        logic [7:0] misc_ops [9];
        alu_ops = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                    ALU_SUBN, ALU_SHL};
        misc_ops = '{F_GET_DT, F_WAIT_KEY, F_SET_DT, F_SET_ST, F_ADD_I, F_FONT, F_BCD,
                     F_STORE, F_LOAD};
        if ($urandom_range(0, 11) == 0) return 16'($urandom);
        x = $urandom;
        y = $urandom;
        n = $urandom;
        kk = $urandom;
        g = group_e'($urandom_range(0, 15));
        case (g)
            GRP_SYS: return ($urandom_range(0, 1) != 0) ? OP_CLS : OP_RET;
            GRP_SE_REG, GRP_SNE_REG: return {g, x, y, 4'h0};
            GRP_ALU: return {g, x, y, alu_ops[$urandom_range(0, 8)]};
            GRP_DRW:
            begin
                n = ($urandom_range(0, 7) == 0) ? 4'hF : 4'($urandom_range(0, 4));
                return {g, x, y, n};
            end
            GRP_KEY: return {g, x, ($urandom_range(0, 1) != 0) ? KEY_SKP : KEY_SKNP};
            GRP_MISC: return {g, x, misc_ops[$urandom_range(0, 8)]};
            default: return {g, x, kk};
        endcase
    endfunction

    task automatic random_run(input int count);
        int sent;
        int r;
        logic [15:0] op;
        logic [15:0] keys;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            keys = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
            if (r < 70)
            begin
                op = pick_instruction();
                send_word('{CMD_WRITE, pc_now, op[15:8], 16'($urandom), 8'($urandom)});
                send_word('{CMD_WRITE, pc_now + 12'd1, op[7:0], 16'($urandom), 8'($urandom)});
                send_word('{CMD_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom)});
                sent += 3;
            end
            else
            begin
                if (r < 80)
                    send_word('{CMD_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom)});
                else if (r < 88)
                    send_word('{CMD_READ,
                                ($urandom_range(0, 7) == 0) ? 12'($urandom)
                                                            : 12'($urandom_range(0, 255)),
                                8'($urandom), keys, 8'($urandom)});
                else if (r < 96)
                    send_word('{CMD_WRITE, 12'($urandom), 8'($urandom), keys, 8'($urandom)});
                else
                    send_word('{CMD_NOP, 12'($urandom), 8'($urandom), keys, 8'($urandom)});
                sent++;
            end
        end
    endtask

    initial
    begin
        rsp_t z;
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 18;
        recv_idle_pct = 72;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        foreach (ram[i]) ram[i] = '0;
        foreach (pixels[i]) pixels[i] = 1'b0;
        foreach (vreg[i]) vreg[i] = '0;
        foreach (ret_stack[i]) ret_stack[i] = '0;
        sp = '0;
        ireg = '0;
        start_addr = START_RESET;
        pc_now = START_RESET;
        delay_t = '0;
        sound_t = '0;
        z = '0;
        z.pc = START_RESET;

        dir_rows[0] = '{'{CMD_EXEC, 12'h0, 8'h0, 16'h0, 8'h0}, 1,
                        '{12'h200, 16'h0, 8'h0, 1'b0, 1'b0, 1'b0, 1'b1}};
        dir_rows[1] = '{'{CMD_READ, 12'd255, 8'h0, 16'h0, 8'h0}, 1, z};
        dir_rows[2] = '{'{CMD_READ, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF}, 1, z};
        dir_rows[3] = '{'{CMD_NOP, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF}, 1, z};
        dir_rows[4] = '{'{CMD_WRITE, 12'hFFF, 8'hFF, 16'h0, 8'h0}, 1, z};
        dir_rows[5] = '{'{CMD_WRITE, 12'h200, 8'h60, 16'h0, 8'h0}, 0, z};
        dir_rows[6] = '{'{CMD_WRITE, 12'h201, 8'hFF, 16'h0, 8'h0}, 0, z};
        dir_rows[7] = '{'{CMD_EXEC, 12'h0, 8'h0, 16'h0, 8'h0}, 0, z};
        dir_rows[8] = '{'{CMD_WRITE, 12'h202, 8'h80, 16'h0, 8'h0}, 0, z};
        dir_rows[9] = '{'{CMD_WRITE, 12'h203, 8'h0E, 16'h0, 8'h0}, 0, z};
        dir_rows[10] = '{'{CMD_EXEC, 12'h0, 8'h0, 16'h0, 8'h0}, 0, z};
        dir_rows[11] = '{'{CMD_WRITE, 12'h204, 8'h00, 16'h0, 8'h0}, 0, z};
        dir_rows[12] = '{'{CMD_WRITE, 12'h205, 8'hE0, 16'h0, 8'h0}, 0, z};
        dir_rows[13] = '{'{CMD_EXEC, 12'h0, 8'h0, 16'h0, 8'h0}, 1,
                         '{12'h206, OP_CLS, 8'h0, 1'b1, 1'b0, 1'b0, 1'b0}};
        dir_rows[14] = '{'{CMD_WRITE, 12'h206, 8'hF0, 16'h0, 8'h0}, 0, z};
        dir_rows[15] = '{'{CMD_WRITE, 12'h207, 8'h0A, 16'h0, 8'h0}, 0, z};
        dir_rows[16] = '{'{CMD_EXEC, 12'h0, 8'h0, 16'h0, 8'h0}, 1,
                         '{12'h206, 16'hF00A, 8'h0, 1'b0, 1'b0, 1'b1, 1'b0}};
        dir_rows[17] = '{'{CMD_EXEC, 12'h0, 8'h0, 16'h8001, 8'h0}, 0, z};
        dir_rows[18] = '{'{CMD_WRITE, 12'h208, 8'hC1, 16'h0, 8'h0}, 0, z};
        dir_rows[19] = '{'{CMD_WRITE, 12'h209, 8'hFF, 16'h0, 8'h0}, 0, z};
        dir_rows[20] = '{'{CMD_EXEC, 12'h0, 8'h0, 16'h0, 8'hFF}, 0, z};
        // full-height sprite from I = 0 at x = V0 = 15, y = V1 = 0xFF: wraps vertically
        dir_rows[21] = '{'{CMD_WRITE, 12'h20A, 8'hD0, 16'h0, 8'h0}, 0, z};
        dir_rows[22] = '{'{CMD_WRITE, 12'h20B, 8'h1F, 16'h0, 8'h0}, 0, z};
        dir_rows[23] = '{'{CMD_EXEC, 12'h0, 8'h0, 16'h0, 8'h0}, 0, z};
        dir_rows[24] = '{'{CMD_READ, 12'd1, 8'h0, 16'h0, 8'h0}, 0, z};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].result);

        set_start(12'h000);
        random_run(RANDOM_ITEMS / 6);
        set_start(12'hFFF);
        random_run(RANDOM_ITEMS / 6);

        send_idle_pct = 72;
        recv_idle_pct = 18;
        set_start(12'($urandom));
        random_run(RANDOM_ITEMS / 6);
        drain();
        random_run(RANDOM_ITEMS / 6);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_start(START_RESET);
        hold_cycles = 400;
        random_run(RANDOM_ITEMS / 3);

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
